### sv/indexed_list_store_assert.svh
// assertion macros shared by the indexed list store
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define ILS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list store: same-cycle check failed");

// next-cycle implication, idle during reset
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list store: next-cycle check failed");

`endif

### sv/ils_pkg.sv
package ils_pkg;

  localparam int IDX_W   = 4;
  localparam int CNT_O_W = 5;
  localparam int VAL_W   = 32;

  // operation codes
  localparam logic [2:0] FN_APPEND   = 3'd0;
  localparam logic [2:0] FN_READ     = 3'd1;
  localparam logic [2:0] FN_DELETE   = 3'd2;
  localparam logic [2:0] FN_FIND     = 3'd3;
  localparam logic [2:0] FN_CLEAR    = 3'd4;
  localparam logic [2:0] FN_REM_LAST = 3'd5;
  localparam logic [2:0] FN_REVERSE  = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]              func;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] data;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_O_W-1:0]      count;
    logic                    is_empty;
  } out_t;

endpackage

### sv/indexed_list_store.sv
// append, clear, remove last, no-op and out of range go straight to the done state; read
// waits on one memory read; find scans from index 0 to the first match or the count; delete
// moves each later entry down one place; reverse swaps pairs from the ends inward, all bound
// by the single memory read port; one item in flight, the next transfer is taken once the
// result is registered; reset (synchronous, active low) zeroes the count and empties the
// output; the entry memory is not swept, entries past the count are never read
`include "indexed_list_store_assert.svh"

module indexed_list_store #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ils_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ils_pkg::out_t out_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W;

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_READ_WAIT = 9'b000000010,
    S_DEL_RUN   = 9'b000000100,
    S_FIND_RUN  = 9'b000001000,
    S_REV_RD_LO = 9'b000010000,
    S_REV_RD_HI = 9'b000100000,
    S_REV_WR_LO = 9'b001000000,
    S_REV_WR_HI = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                  lo_r, lo_nxt;
  logic [AW-1:0]                  hi_r, hi_nxt;
  logic [ils_pkg::VAL_W-1:0]      value_r, value_nxt;
  logic [ils_pkg::VAL_W-1:0]      tmp_r, tmp_nxt;
  logic [1:0]                     status_r, status_nxt;
  logic signed [ils_pkg::VAL_W-1:0] data_r, data_nxt;
  logic [ils_pkg::IDX_W-1:0]      fidx_r, fidx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ils_pkg::out_t                  out_data_r, out_data_nxt;

  // memory port
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ils_pkg::VAL_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [ils_pkg::VAL_W-1:0] ram_rdata;

  logic           in_xfer;
  logic           out_free;
  logic [CMPW-1:0] idx_w, cnt_w;
  logic           idx_ok;
  logic [CW-1:0]  idx_c, idx_plus;
  logic [CW-1:0]  ptr_plus;
  logic [AW-1:0]  lo_plus, hi_minus;

  ils_ram #(
    .WIDTH(ils_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // index range check at a width that holds both operands
  assign idx_w    = CMPW'(in_data.index);
  assign cnt_w    = CMPW'(count_r);
  assign idx_ok   = idx_w < cnt_w;
  // only used when the index is in range, so it fits the count width
  assign idx_c    = CW'(in_data.index);
  assign idx_plus = CW'(idx_c + 1'b1);
  assign ptr_plus = CW'(ptr_r + 1'b1);
  assign lo_plus  = AW'(lo_r + 1'b1);
  assign hi_minus = AW'(hi_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    value_nxt     = value_r;
    tmp_nxt       = tmp_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    fidx_nxt      = fidx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(count_r);
    ram_wdata     = in_data.value;
    ram_re        = 1'b0;
    ram_raddr     = AW'(in_data.index);

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt = ils_pkg::ST_OK;
          data_nxt   = '0;
          fidx_nxt   = '0;
          value_nxt  = in_data.value;
          state_nxt  = S_DONE;
          unique case (in_data.func)
            ils_pkg::FN_APPEND: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ils_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            ils_pkg::FN_READ: begin
              if (!idx_ok) begin
                status_nxt = ils_pkg::ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_READ_WAIT;
              end
            end
            ils_pkg::FN_DELETE: begin
              if (!idx_ok) begin
                status_nxt = ils_pkg::ST_RANGE;
              end else if (idx_plus < count_r) begin
                // start moving later entries down one place
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_plus);
                ptr_nxt   = idx_plus;
                state_nxt = S_DEL_RUN;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
              end
            end
            ils_pkg::FN_FIND: begin
              if (count_r == '0) begin
                status_nxt = ils_pkg::ST_NOTFOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_nxt   = '0;
                state_nxt = S_FIND_RUN;
              end
            end
            ils_pkg::FN_CLEAR: begin
              count_nxt = '0;
            end
            ils_pkg::FN_REM_LAST: begin
              if (count_r == '0) begin
                status_nxt = ils_pkg::ST_RANGE;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
              end
            end
            ils_pkg::FN_REVERSE: begin
              if (count_r > CW'(1)) begin
                lo_nxt    = '0;
                hi_nxt    = AW'(count_r - 1'b1);
                state_nxt = S_REV_RD_LO;
              end
            end
            default: begin
              // unused code: no operation
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        data_nxt  = $signed(ram_rdata);
        state_nxt = S_DONE;
      end
      S_DEL_RUN: begin
        // entry ptr arrives, lands one place lower, next read overlaps
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_r - 1'b1);
        ram_wdata = ram_rdata;
        if (ptr_plus < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_plus);
          ptr_nxt   = ptr_plus;
        end else begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_DONE;
        end
      end
      S_FIND_RUN: begin
        // compare entry ptr while the following one is fetched
        if (ram_rdata == value_r) begin
          fidx_nxt  = ils_pkg::IDX_W'(ptr_r);
          state_nxt = S_DONE;
        end else if (ptr_plus < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_plus);
          ptr_nxt   = ptr_plus;
        end else begin
          status_nxt = ils_pkg::ST_NOTFOUND;
          state_nxt  = S_DONE;
        end
      end
      S_REV_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = lo_r;
        state_nxt = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        tmp_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = hi_r;
        state_nxt = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata;
        state_nxt = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        lo_nxt    = lo_plus;
        hi_nxt    = hi_minus;
        if (lo_plus < hi_minus) begin
          state_nxt = S_REV_RD_LO;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.data        = data_r;
          out_data_nxt.found_index = fidx_r;
          out_data_nxt.count       = ils_pkg::CNT_O_W'(count_r);
          out_data_nxt.is_empty    = (count_r == '0);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    value_r    <= value_nxt;
    tmp_r      <= tmp_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    fidx_r     <= fidx_nxt;
    out_data_r <= out_data_nxt;
  end

  // the count never passes the capacity
  `ILS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  // an accepted item always leaves the idle state
  `ILS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_xfer, state_r != S_IDLE)
  // a finished item with a free output register is delivered and the block goes idle
  `ILS_ASSERT_NEXT(a_done_load, clk, rst_n, (state_r == S_DONE) && out_free,
                   out_valid_r && (state_r == S_IDLE))
  // a search never writes the memory
  `ILS_ASSERT_NOW(a_find_no_write, clk, rst_n, state_r == S_FIND_RUN, !ram_we)

endmodule

### sv/ils_ram.sv
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/tb_indexed_list_store.sv
module tb_indexed_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;
  // func code seven has no operation behind it, the block must treat it as a no-op
  localparam logic [2:0] FN_UNUSED = 3'd7;
  // longest single operation is a full reverse of 8 pairs
  localparam int SETTLE_CYCLES = 60;
  // long receiver hold-off, well past anything the block can absorb
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ils_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ils_pkg::out_t out_data;

  // idling controls, set by the tests only while no result is outstanding
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // shadow copy of the list, updated at each input transfer
  logic signed [31:0] list_vals [LIST_DEPTH];
  int   list_len = 0;
  ils_pkg::out_t pending_results [$];

  int mismatches = 0;
  int transfers_in = 0;
  int results_checked = 0;
  int peak_len = 0;
  int status_seen [4] = '{default: 0};

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_list_store #(
    .DEPTH (LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one line per mismatch
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // applies one operation to the shadow list and gives the result it must produce
  function automatic ils_pkg::out_t apply_list_op(ils_pkg::in_t op);
    ils_pkg::out_t r;
    logic signed [31:0] held;
    int lo;
    int hi;
    r = '0;
    r.status = ils_pkg::ST_OK;
    case (op.func)
      ils_pkg::FN_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ils_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = op.value;
          list_len++;
        end
      end
      ils_pkg::FN_READ: begin
        if (int'(op.index) >= list_len) r.status = ils_pkg::ST_RANGE;
        else r.data = list_vals[op.index];
      end
      ils_pkg::FN_DELETE: begin
        if (int'(op.index) >= list_len) begin
          r.status = ils_pkg::ST_RANGE;
        end else begin
          // close the gap: everything above moves down one place
          for (int i = int'(op.index); i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      ils_pkg::FN_FIND: begin
        r.status = ils_pkg::ST_NOTFOUND;
        // lowest matching position wins on duplicates
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_vals[i] == op.value) begin
            r.status = ils_pkg::ST_OK;
            r.found_index = i[3:0];
          end
        end
      end
      ils_pkg::FN_CLEAR: begin
        list_len = 0;
      end
      ils_pkg::FN_REM_LAST: begin
        if (list_len == 0) r.status = ils_pkg::ST_RANGE;
        else list_len--;
      end
      ils_pkg::FN_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          held = list_vals[lo];
          list_vals[lo] = list_vals[hi];
          list_vals[hi] = held;
          lo++;
          hi--;
        end
      end
      default: begin
        // unused code, nothing changes
      end
    endcase
    r.count = list_len[4:0];
    r.is_empty = (list_len == 0);
    if (list_len > peak_len) peak_len = list_len;
    return r;
  endfunction

  // random operation, biased towards appends so the list fills and empties in turn;
  // indexes mostly land inside the list and search values often on stored ones
  function automatic ils_pkg::in_t make_list_op(int append_pct);
    ils_pkg::in_t op;
    int sel;
    sel = $urandom_range(19);
    if ($urandom_range(99) < append_pct) op.func = ils_pkg::FN_APPEND;
    else if (sel < 4) op.func = ils_pkg::FN_READ;
    else if (sel < 7) op.func = ils_pkg::FN_DELETE;
    else if (sel < 11) op.func = ils_pkg::FN_FIND;
    else if (sel == 11) op.func = ils_pkg::FN_CLEAR;
    else if (sel < 15) op.func = ils_pkg::FN_REM_LAST;
    else if (sel < 18) op.func = ils_pkg::FN_REVERSE;
    else if (sel == 18) op.func = FN_UNUSED;
    else op.func = ils_pkg::FN_APPEND;

    if (list_len > 0 && $urandom_range(3) != 0) op.index = 4'($urandom_range(list_len - 1));
    else op.index = 4'($urandom_range(15));

    sel = $urandom_range(9);
    if (sel < 4 && list_len > 0) op.value = list_vals[$urandom_range(list_len - 1)];
    else if (sel < 6) op.value = $signed($urandom_range(4)) - 2;
    else if (sel == 9) op.value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else op.value = $urandom;
    return op;
  endfunction

  // offers one item, with random idle cycles first, and records its expected result
  // once the transfer happens; valid stays high afterwards until the next call decides
  task automatic send_item(ils_pkg::in_t op);
    ils_pkg::out_t want;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    want = apply_list_op(op);
    pending_results.insert(pending_results.size(), want);
    transfers_in++;
    status_seen[want.status]++;
  endtask

  task automatic send_op(logic [2:0] func, logic signed [31:0] value, logic [3:0] index);
    ils_pkg::in_t op;
    op.func  = func;
    op.value = value;
    op.index = index;
    send_item(op);
  endtask

  // sender goes quiet until every outstanding result has been seen
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, or a counted long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker, compares every output transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    ils_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_data.data, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.data !== want.data)
          report_mismatch("data", out_data.data, want.data);
        if (out_data.found_index !== want.found_index)
          report_mismatch("found_index", 32'(out_data.found_index), 32'(want.found_index));
        if (out_data.count !== want.count)
          report_mismatch("count", 32'(out_data.count), 32'(want.count));
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
      end
    end
  end

  // corner cases: every operation on an empty list, extreme values, duplicates,
  // indexes at and past the count, the unused code
  task automatic test_directed_corners();
    send_op(ils_pkg::FN_READ, 0, 0);
    send_op(ils_pkg::FN_DELETE, 0, 0);
    send_op(ils_pkg::FN_REM_LAST, 0, 0);
    send_op(ils_pkg::FN_FIND, 5, 0);
    send_op(ils_pkg::FN_CLEAR, 0, 0);
    send_op(ils_pkg::FN_REVERSE, 0, 0);
    send_op(FN_UNUSED, '1, 4'hF);
    send_op(ils_pkg::FN_APPEND, 32'sh7FFF_FFFF, 0);
    send_op(ils_pkg::FN_APPEND, 32'sh8000_0000, 0);
    send_op(ils_pkg::FN_APPEND, -1, 0);
    send_op(ils_pkg::FN_APPEND, 32'sh7FFF_FFFF, 0);
    send_op(ils_pkg::FN_FIND, 32'sh7FFF_FFFF, 0);
    send_op(ils_pkg::FN_READ, 0, 3);
    send_op(ils_pkg::FN_READ, 0, 4);
    send_op(ils_pkg::FN_DELETE, 0, 4'hF);
    send_op(ils_pkg::FN_REVERSE, 0, 0);
    send_op(ils_pkg::FN_FIND, 32'sh8000_0000, 0);
    send_op(ils_pkg::FN_FIND, 32'sh0001_2345, 0);
    send_op(ils_pkg::FN_DELETE, 0, 0);
    send_op(ils_pkg::FN_REM_LAST, 0, 0);
    send_op(ils_pkg::FN_CLEAR, 0, 0);
    wait_for_results();
  endtask

  // receiver holds off while appends keep coming, so the block backs up and the
  // list overflows; then the slowest operations on the full list and a read one past the end
  task automatic test_backpressure_fill();
    send_op(ils_pkg::FN_CLEAR, 0, 0);
    wait_for_results();
    hold_left = HOLD_CYCLES;
    repeat (LIST_DEPTH + 6) send_op(ils_pkg::FN_APPEND, $urandom, 4'($urandom_range(15)));
    send_op(ils_pkg::FN_REVERSE, 0, 0);
    send_op(ils_pkg::FN_FIND, 32'sh0BAD_0000, 0);
    send_op(ils_pkg::FN_DELETE, 0, 0);
    send_op(ils_pkg::FN_READ, 0, 4'hF);
    wait_for_results();
  endtask

  task automatic run_random_items(int n_items);
    int append_pct;
    append_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      // shift the append bias now and then so the fill level wanders end to end
      if (k % 40 == 0) append_pct = $urandom_range(30, 75);
      send_item(make_list_op(append_pct));
    end
    wait_for_results();
  endtask

  task automatic test_random_no_idle();
    idle_pct = 0;
    stall_pct = 0;
    run_random_items(280);
  endtask

  task automatic test_random_sender_gaps();
    idle_pct = 55;
    stall_pct = 0;
    run_random_items(260);
  endtask

  task automatic test_random_receiver_stalls();
    idle_pct = 0;
    stall_pct = 55;
    run_random_items(260);
  endtask

  task automatic test_random_both_sides();
    idle_pct = 38;
    stall_pct = 38;
    run_random_items(260);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_backpressure_fill();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_sides();

    // let anything stray come out before judging
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d transfers in, %0d results checked, list filled to %0d of %0d",
             transfers_in, results_checked, peak_len, LIST_DEPTH);
    $display("outcomes: %0d ok, %0d out of range or empty, %0d full, %0d not found",
             status_seen[ils_pkg::ST_OK], status_seen[ils_pkg::ST_RANGE],
             status_seen[ils_pkg::ST_FULL], status_seen[ils_pkg::ST_NOTFOUND]);
    if (mismatches == 0) begin
      $display("** indexed_list_store: PASSED **");
    end else begin
      $display("** indexed_list_store: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** indexed_list_store: FAILED **");
    $finish;
  end

endmodule
